FILE: design/mvc_pkg.sv
// ----------------------------------------------------------------------------
// mvc_pkg
// Types, request and status codes, and the volume-to-attenuation table
// shared by the multichannel volume controller.
// ----------------------------------------------------------------------------
package mvc_pkg;

   localparam int MASK_W = 6;

   localparam logic [2:0] REQ_SET_VOLUME   = 3'd0;
   localparam logic [2:0] REQ_STEP_VOLUME  = 3'd1;
   localparam logic [2:0] REQ_SET_OFFSET   = 3'd2;
   localparam logic [2:0] REQ_RESET_OFFSET = 3'd3;
   localparam logic [2:0] REQ_SET_MUTE     = 3'd4;
   localparam logic [2:0] REQ_QUERY        = 3'd5;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_ARG  = 2'd1;
   localparam logic [1:0] STAT_INACTIVE = 2'd2;

   localparam logic [2:0] CSR_ACTIVE_MASK  = 3'd0;
   localparam logic [2:0] CSR_OFFSET_LIMIT = 3'd1;
   localparam logic [2:0] CSR_LINEAR       = 3'd2;
   localparam logic [2:0] CSR_BOOT_VOLUME  = 3'd3;
   localparam logic [2:0] CSR_BOOT_MUTE    = 3'd4;

   localparam logic [6:0] VOL_MAX     = 7'd100;
   localparam logic [6:0] OFS_CAP     = 7'd78;
   localparam logic [6:0] BOOT_VOLUME = 7'd50;
   localparam logic       BOOT_MUTE   = 1'b0;

   // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x < 2^14
   localparam logic [13:0] RECIP       = 14'd10486;
   localparam int          RECIP_SHIFT = 20;

   localparam logic [6:0] LOG_TABLE [0:100] = '{
      7'd79, 7'd79, 7'd79, 7'd78, 7'd78, 7'd78, 7'd77, 7'd77, 7'd77, 7'd76,
      7'd76, 7'd75, 7'd75, 7'd74, 7'd74, 7'd73, 7'd73, 7'd72, 7'd72, 7'd71,
      7'd71, 7'd70, 7'd70, 7'd69, 7'd68, 7'd68, 7'd67, 7'd66, 7'd66, 7'd65,
      7'd64, 7'd64, 7'd63, 7'd62, 7'd62, 7'd61, 7'd60, 7'd59, 7'd59, 7'd58,
      7'd57, 7'd56, 7'd56, 7'd55, 7'd54, 7'd53, 7'd52, 7'd52, 7'd51, 7'd50,
      7'd49, 7'd48, 7'd47, 7'd47, 7'd46, 7'd45, 7'd44, 7'd43, 7'd42, 7'd41,
      7'd40, 7'd39, 7'd38, 7'd37, 7'd36, 7'd35, 7'd34, 7'd33, 7'd32, 7'd31,
      7'd30, 7'd29, 7'd28, 7'd27, 7'd26, 7'd25, 7'd24, 7'd23, 7'd22, 7'd21,
      7'd20, 7'd19, 7'd18, 7'd17, 7'd16, 7'd15, 7'd14, 7'd13, 7'd12, 7'd11,
      7'd10, 7'd9,  7'd8,  7'd7,  7'd6,  7'd5,  7'd4,  7'd3,  7'd2,  7'd1,
      7'd0
   };

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_DIV,
      S_READ,
      S_WRITE,
      S_QUERY
   } state_type;

endpackage

FILE: design/multichannel_volume_controller.sv
// ----------------------------------------------------------------------------
// multichannel_volume_controller
// Master volume / per-channel offset controller. Offsets and last written
// attenuations live in two small synchronous memories; a refresh walks the
// channels, reads each active entry, clamps base minus offset and writes it back.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// req       req_valid / req_ready  req_type .. req_mute_on
// rsp       rsp_valid / rsp_ready  rsp_status .. rsp_last
// csr       csr_write_en           csr_index, csr_wdata
//
// Rejected, mute and status-only requests are answered straight from idle.
// Query: one memory read, then S_QUERY. Refresh: S_BASE and S_DIV form the base
// attenuation, then S_READ and S_WRITE per active channel, S_READ only per skipped one.
// Memory valid bits clear at reset; no clearing pass. A full result
// register stalls the scan on the current channel.
// ----------------------------------------------------------------------------
module multichannel_volume_controller
   import mvc_pkg::*;
#(
   parameter int NUM_CHANNELS = 6,
   parameter int MAX_ATTEN    = 79
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic [7:0]        req_volume,
   input  logic signed [8:0] req_step,
   input  logic [2:0]        req_channel,
   input  logic signed [7:0] req_offset,
   input  logic              req_mute_on,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_write_valid,
   output logic [2:0]        rsp_out_channel,
   output logic [6:0]        rsp_attenuation,
   output logic signed [7:0] rsp_channel_offset,
   output logic [6:0]        rsp_volume_level,
   output logic              rsp_muted,
   output logic              rsp_last,

   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_wdata
);

   localparam int          IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [6:0]  ATTEN_M = 7'(MAX_ATTEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   // configuration
   logic [MASK_W-1:0] mask_ff;
   logic [6:0]        limit_ff;
   logic              linear_ff;

   // state
   state_type         state_ff, state_in;
   logic [6:0]        master_ff, master_in;
   logic              mute_ff, mute_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [13:0]       prod_ff, prod_in;
   logic [6:0]        base_ff, base_in;

   // memories
   logic signed [7:0] ofs_mem [NUM_CHANNELS];
   logic [6:0]        atn_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] ofs_vld_ff;
   logic [NUM_CHANNELS-1:0] atn_vld_ff;
   logic signed [7:0] ofs_rd_ff;
   logic [6:0]        atn_rd_ff;
   logic              ofs_rdv_ff;
   logic              atn_rdv_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              atn_we;
   logic [6:0]        atn_wdata;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_load;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_wv_ff, rsp_wv_in;
   logic [2:0]        rsp_ch_ff, rsp_ch_in;
   logic [6:0]        rsp_atn_ff, rsp_atn_in;
   logic signed [7:0] rsp_ofs_ff, rsp_ofs_in;
   logic [6:0]        rsp_mv_ff, rsp_mv_in;
   logic              rsp_mu_ff, rsp_mu_in;
   logic              rsp_last_ff, rsp_last_in;

   // request decode
   logic [NUM_CHANNELS-1:0] active_vec;
   logic              req_fire, out_free;
   logic [6:0]        lim;
   logic signed [8:0] ofs9, lim9;
   logic              ofs_bad, step_bad;
   logic signed [9:0] nv;
   logic [6:0]        nv_clamp;
   logic              ch_in_range;
   logic [IDX_W-1:0]  ch_idx;
   logic [1:0]        ch_status;
   logic              go_refresh, go_query, dec_scan;
   logic [1:0]        dec_status;
   logic [6:0]        dec_master;
   logic              dec_mute;
   logic              ofs_wr, ofs_clear;

   // scan datapath
   logic [27:0]       quot_full;
   logic [7:0]        quot;
   logic [6:0]        base_sel;
   logic signed [7:0] ofs_eff;
   logic signed [9:0] t_raw;
   logic [6:0]        t_clamp;
   logic              is_last;
   logic [NUM_CHANNELS-1:0] above;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_active
      if (i < MASK_W) begin : g_bit
         assign active_vec[i] = mask_ff[i];
      end else begin : g_none
         assign active_vec[i] = 1'b0;
      end
   end

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------- request decode ----------------
   assign lim      = (limit_ff > OFS_CAP) ? OFS_CAP : limit_ff;
   assign ofs9     = {req_offset[7], req_offset};
   assign lim9     = {2'b00, lim};
   assign ofs_bad  = (ofs9 > lim9) || (ofs9 < -lim9);
   assign step_bad = (req_step > 9'sd100) || (req_step < -9'sd100);
   assign nv       = $signed({3'b000, master_ff}) + $signed({req_step[8], req_step});
   assign nv_clamp = (nv < 10'sd0) ? 7'd0 :
                     (nv > $signed({3'b000, VOL_MAX})) ? VOL_MAX : nv[6:0];

   assign ch_in_range = (req_channel != 3'd0) && ({1'b0, req_channel} <= 4'(NUM_CHANNELS));
   assign ch_idx      = IDX_W'(req_channel - 3'd1);
   assign ch_status   = !ch_in_range ? STAT_BAD_ARG :
                        (active_vec[ch_idx] ? STAT_OK : STAT_INACTIVE);

   always_comb begin
      go_refresh = 1'b0;
      go_query   = 1'b0;
      dec_status = STAT_OK;
      dec_master = master_ff;
      dec_mute   = mute_ff;
      ofs_wr     = 1'b0;
      ofs_clear  = 1'b0;
      case (req_type)
         REQ_SET_VOLUME: begin
            if (req_volume > {1'b0, VOL_MAX}) begin
               dec_status = STAT_BAD_ARG;
            end else begin
               dec_master = req_volume[6:0];
               go_refresh = 1'b1;
            end
         end
         REQ_STEP_VOLUME: begin
            if (step_bad) begin
               dec_status = STAT_BAD_ARG;
            end else if (req_step != 9'sd0) begin
               dec_master = nv_clamp;
               go_refresh = 1'b1;
            end
         end
         REQ_SET_OFFSET: begin
            if (ofs_bad) begin
               dec_status = STAT_BAD_ARG;
            end else if (ch_status != STAT_OK) begin
               dec_status = ch_status;
            end else begin
               ofs_wr     = 1'b1;
               go_refresh = 1'b1;
            end
         end
         REQ_RESET_OFFSET: begin
            ofs_clear  = 1'b1;
            go_refresh = 1'b1;
         end
         REQ_SET_MUTE: begin
            dec_mute = req_mute_on;
         end
         REQ_QUERY: begin
            if (ch_status != STAT_OK) begin
               dec_status = ch_status;
            end else begin
               go_query = 1'b1;
            end
         end
         default: begin
            dec_status = STAT_BAD_ARG;
         end
      endcase
   end

   assign dec_scan  = go_refresh && (|active_vec);
   assign master_in = req_fire ? dec_master : master_ff;
   assign mute_in   = req_fire ? dec_mute : mute_ff;

   // ---------------- scan datapath ----------------
   assign quot_full = 28'(prod_ff) * 28'(RECIP);
   assign quot      = 8'(quot_full >> RECIP_SHIFT);
   assign base_sel  = linear_ff ? ((quot > {1'b0, ATTEN_M}) ? ATTEN_M : quot[6:0])
                                : ((LOG_TABLE[master_ff] > ATTEN_M) ? ATTEN_M
                                                                    : LOG_TABLE[master_ff]);

   assign ofs_eff = ofs_rdv_ff ? ofs_rd_ff : 8'sd0;
   assign t_raw   = $signed({3'b000, base_ff}) - $signed({{2{ofs_eff[7]}}, ofs_eff});
   assign t_clamp = (t_raw < 10'sd0) ? 7'd0 :
                    (t_raw > $signed({3'b000, ATTEN_M})) ? ATTEN_M : t_raw[6:0];

   assign above   = (active_vec >> scan_ff) >> 1;
   assign is_last = (above == '0);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && dec_scan) begin
               state_in = S_BASE;
            end else if (req_fire && go_query) begin
               state_in = S_QUERY;
            end
         end
         S_BASE:  state_in = S_DIV;
         S_DIV:   state_in = S_READ;
         S_READ: begin
            if (active_vec[scan_ff]) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               state_in = is_last ? S_IDLE : S_READ;
            end
         end
         S_QUERY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      req_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = scan_ff;
      atn_we        = 1'b0;
      atn_wdata     = t_clamp;
      scan_in       = scan_ff;
      prod_in       = prod_ff;
      base_in       = base_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_wv_in     = 1'b0;
      rsp_ch_in     = 3'd0;
      rsp_atn_in    = 7'd0;
      rsp_ofs_in    = 8'sd0;
      rsp_mv_in     = master_ff;
      rsp_mu_in     = mute_ff;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            scan_in   = '0;
            rd_addr   = ch_idx;
            if (req_fire && go_query) begin
               rd_en   = 1'b1;
               scan_in = ch_idx;
            end
            if (req_fire && !dec_scan && !go_query) begin
               rsp_load      = 1'b1;
               rsp_status_in = dec_status;
               rsp_mv_in     = dec_master;
               rsp_mu_in     = dec_mute;
            end
         end
         S_BASE: begin
            prod_in = 14'(VOL_MAX - master_ff) * 14'(ATTEN_M);
         end
         S_DIV: begin
            base_in = base_sel;
         end
         S_READ: begin
            if (active_vec[scan_ff]) begin
               rd_en = 1'b1;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               atn_we      = 1'b1;
               rsp_load    = 1'b1;
               rsp_wv_in   = 1'b1;
               rsp_ch_in   = 3'(scan_ff) + 3'd1;
               rsp_atn_in  = t_clamp;
               rsp_ofs_in  = ofs_eff;
               rsp_last_in = is_last;
               if (!is_last && (scan_ff != LAST_IDX)) begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_QUERY: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               rsp_ch_in  = 3'(scan_ff) + 3'd1;
               rsp_atn_in = atn_rdv_ff ? atn_rd_ff : ATTEN_M;
               rsp_ofs_in = ofs_eff;
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '1;
         limit_ff  <= 7'd0;
         linear_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ACTIVE_MASK:  mask_ff   <= csr_wdata[MASK_W-1:0];
            CSR_OFFSET_LIMIT: limit_ff  <= csr_wdata;
            CSR_LINEAR:       linear_ff <= csr_wdata[0];
            // boot-value writes are ignored; reset loads the BOOT_VOLUME and BOOT_MUTE constants
            CSR_BOOT_VOLUME, CSR_BOOT_MUTE: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         master_ff    <= (BOOT_VOLUME > VOL_MAX) ? VOL_MAX : BOOT_VOLUME;
         mute_ff      <= BOOT_MUTE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ofs_vld_ff   <= '0;
         atn_vld_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         master_ff <= master_in;
         mute_ff   <= mute_in;
         scan_ff   <= scan_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire && ofs_clear) begin
            ofs_vld_ff <= '0;
         end else if (req_fire && ofs_wr) begin
            ofs_vld_ff[ch_idx] <= 1'b1;
         end
         if (atn_we) begin
            atn_vld_ff[scan_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_wv_ff     <= rsp_wv_in;
         rsp_ch_ff     <= rsp_ch_in;
         rsp_atn_ff    <= rsp_atn_in;
         rsp_ofs_ff    <= rsp_ofs_in;
         rsp_mv_ff     <= rsp_mv_in;
         rsp_mu_ff     <= rsp_mu_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // offset memory
   always_ff @(posedge clock) begin
      if (req_fire && ofs_wr) begin
         ofs_mem[ch_idx] <= req_offset;
      end
      if (rd_en) begin
         ofs_rd_ff  <= ofs_mem[rd_addr];
         ofs_rdv_ff <= ofs_vld_ff[rd_addr];
      end
   end

   // attenuation memory
   always_ff @(posedge clock) begin
      if (atn_we) begin
         atn_mem[scan_ff] <= atn_wdata;
      end
      if (rd_en) begin
         atn_rd_ff  <= atn_mem[rd_addr];
         atn_rdv_ff <= atn_vld_ff[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_write_valid    = rsp_wv_ff;
   assign rsp_out_channel    = rsp_ch_ff;
   assign rsp_attenuation    = rsp_atn_ff;
   assign rsp_channel_offset = rsp_ofs_ff;
   assign rsp_volume_level   = rsp_mv_ff;
   assign rsp_muted          = rsp_mu_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_master_range: assert property (@(posedge clock) disable iff (reset)
      master_ff <= VOL_MAX)
      else $error("master volume out of range");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_status == STAT_OK && rsp_out_channel != 3'd0)
      else $error("write result without ok status or channel");

   a_atten_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_attenuation <= ATTEN_M)
      else $error("attenuation above maximum");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request accepted during scan");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel volume controller. A clocked
// driver feeds requests from a backlog queue, a built-in model of the
// controller forecasts every result, and a clocked monitor compares each
// returned result field by field. Runs a directed set, then random traffic
// over several register settings; random idle bursts on both channels but in the last.
// ----------------------------------------------------------------------------
module testbench
   import mvc_pkg::*;
();

   localparam int NCH         = 6;
   localparam int ATTEN_TOP   = 79;
   localparam int VOL_TOP     = 100;
   localparam int OFS_CEIL    = 78;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 20;
   localparam int PHASE_ITEMS = 45;
   localparam int NUM_PHASES  = 6;

   localparam logic [6:0] DB_CURVE [0:100] = '{
      7'd79, 7'd79, 7'd79, 7'd78, 7'd78, 7'd78, 7'd77, 7'd77, 7'd77, 7'd76,
      7'd76, 7'd75, 7'd75, 7'd74, 7'd74, 7'd73, 7'd73, 7'd72, 7'd72, 7'd71,
      7'd71, 7'd70, 7'd70, 7'd69, 7'd68, 7'd68, 7'd67, 7'd66, 7'd66, 7'd65,
      7'd64, 7'd64, 7'd63, 7'd62, 7'd62, 7'd61, 7'd60, 7'd59, 7'd59, 7'd58,
      7'd57, 7'd56, 7'd56, 7'd55, 7'd54, 7'd53, 7'd52, 7'd52, 7'd51, 7'd50,
      7'd49, 7'd48, 7'd47, 7'd47, 7'd46, 7'd45, 7'd44, 7'd43, 7'd42, 7'd41,
      7'd40, 7'd39, 7'd38, 7'd37, 7'd36, 7'd35, 7'd34, 7'd33, 7'd32, 7'd31,
      7'd30, 7'd29, 7'd28, 7'd27, 7'd26, 7'd25, 7'd24, 7'd23, 7'd22, 7'd21,
      7'd20, 7'd19, 7'd18, 7'd17, 7'd16, 7'd15, 7'd14, 7'd13, 7'd12, 7'd11,
      7'd10, 7'd9,  7'd8,  7'd7,  7'd6,  7'd5,  7'd4,  7'd3,  7'd2,  7'd1,
      7'd0
   };

   typedef struct {
      logic [2:0]        kind;
      logic [7:0]        volume;
      logic signed [8:0] step;
      logic [2:0]        channel;
      logic signed [7:0] offset;
      logic              mute_on;
   } req_item_type;

   typedef struct {
      logic [1:0]        status;
      logic              write_valid;
      logic [2:0]        channel;
      logic [6:0]        atten;
      logic signed [7:0] offset;
      logic [6:0]        master;
      logic              muted;
      logic              last;
   } rsp_item_type;

   typedef struct {
      logic [6:0] mask;
      logic [6:0] limit;
      logic [6:0] linear;
      logic [6:0] boot_vol;
      logic [6:0] boot_mute;
   } csr_set_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_type = '0;
   logic [7:0]        req_volume = '0;
   logic signed [8:0] req_step = '0;
   logic [2:0]        req_channel = '0;
   logic signed [7:0] req_offset = '0;
   logic              req_mute_on = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_write_valid;
   logic [2:0]        rsp_out_channel;
   logic [6:0]        rsp_attenuation;
   logic signed [7:0] rsp_channel_offset;
   logic [6:0]        rsp_volume_level;
   logic              rsp_muted;
   logic              rsp_last;
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [6:0]        csr_wdata = '0;

   // controller shadow: registers and state
   logic [5:0]        cfg_mask = 6'h3F;
   logic [6:0]        cfg_limit = '0;
   logic              cfg_linear = 1'b0;
   logic [6:0]        cfg_boot_vol = 7'd50;
   logic              cfg_boot_mute = 1'b0;
   logic [6:0]        level;
   logic              mute_state;
   logic signed [7:0] ofs_mem [NCH];
   logic [6:0]        att_mem [NCH];

   req_item_type req_backlog [$];
   rsp_item_type rsp_forecast_q [$];
   req_item_type cur_req;
   int        gap_left = 0;
   int        stall_left = 0;
   int        idle_cycles = 0;
   int        mismatch_cnt = 0;
   logic      steady = 1'b0;

   multichannel_volume_controller DUT (.*);

   always #5 clock = ~clock;

   function automatic logic [1:0] channel_status(logic [2:0] ch);
      if (ch < 1 || ch > NCH) return STAT_BAD_ARG;
      return cfg_mask[ch - 1] ? STAT_OK : STAT_INACTIVE;
   endfunction

   task automatic push_single(logic [1:0] st);
      rsp_item_type r;
      r = '{st, 1'b0, 3'd0, 7'd0, 8'sd0, level, mute_state, 1'b1};
      rsp_forecast_q.push_back(r);
   endtask

   task automatic refresh_channels();
      rsp_item_type w;
      int        vol;
      int        base;
      int        t;
      int        n;
      vol = (level > VOL_TOP) ? VOL_TOP : int'(level);
      base = cfg_linear ? ((VOL_TOP - vol) * ATTEN_TOP) / VOL_TOP : int'(DB_CURVE[vol]);
      if (base > ATTEN_TOP) base = ATTEN_TOP;
      n = 0;
      for (int i = 0; i < NCH; i++) begin
         if (cfg_mask[i]) begin
            t = base - int'(ofs_mem[i]);
            if (t < 0) t = 0;
            if (t > ATTEN_TOP) t = ATTEN_TOP;
            att_mem[i] = 7'(t);
            w = '{STAT_OK, 1'b1, 3'(i + 1), 7'(t), ofs_mem[i], level, mute_state, 1'b0};
            rsp_forecast_q.push_back(w);
            n++;
         end
      end
      if (n == 0) begin
         push_single(STAT_OK);
      end else begin
         w = rsp_forecast_q.pop_back();
         w.last = 1'b1;
         rsp_forecast_q.push_back(w);
      end
   endtask

   task automatic forecast_request(req_item_type r);
      rsp_item_type q;
      logic [1:0] st;
      int         lim;
      int         s;
      int         o;
      int         nv;
      int         ch;
      lim = (cfg_limit > OFS_CEIL) ? OFS_CEIL : int'(cfg_limit);
      s = int'(r.step);
      o = int'(r.offset);
      ch = int'(r.channel);
      case (r.kind)
         REQ_SET_VOLUME: begin
            if (r.volume > VOL_TOP) begin
               push_single(STAT_BAD_ARG);
            end else begin
               level = r.volume[6:0];
               refresh_channels();
            end
         end
         REQ_STEP_VOLUME: begin
            if (s < -VOL_TOP || s > VOL_TOP) begin
               push_single(STAT_BAD_ARG);
            end else if (s == 0) begin
               push_single(STAT_OK);
            end else begin
               nv = int'(level) + s;
               if (nv > VOL_TOP) nv = VOL_TOP;
               if (nv < 0) nv = 0;
               level = 7'(nv);
               refresh_channels();
            end
         end
         REQ_SET_OFFSET: begin
            st = channel_status(r.channel);
            if (o < -lim || o > lim) begin
               push_single(STAT_BAD_ARG);
            end else if (st != STAT_OK) begin
               push_single(st);
            end else begin
               ofs_mem[ch - 1] = r.offset;
               refresh_channels();
            end
         end
         REQ_RESET_OFFSET: begin
            for (int i = 0; i < NCH; i++) ofs_mem[i] = '0;
            refresh_channels();
         end
         REQ_SET_MUTE: begin
            mute_state = r.mute_on;
            push_single(STAT_OK);
         end
         REQ_QUERY: begin
            st = channel_status(r.channel);
            if (st != STAT_OK) begin
               push_single(st);
            end else begin
               q = '{STAT_OK, 1'b0, r.channel, att_mem[ch - 1], ofs_mem[ch - 1], level,
                     mute_state, 1'b1};
               rsp_forecast_q.push_back(q);
            end
         end
         default: push_single(STAT_BAD_ARG);
      endcase
   endtask

   function automatic req_item_type mk(logic [2:0] kind, int vol, int stp, int ch, int ofs,
                                       int mon);
      req_item_type r;
      r = '{kind, 8'(vol), 9'(stp), 3'(ch), 8'(ofs), 1'(mon)};
      return r;
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int        lim;
      lim = (cfg_limit > OFS_CEIL) ? OFS_CEIL : int'(cfg_limit);
      r.kind = ($urandom_range(0, 24) == 0) ? 3'(REQ_QUERY + $urandom_range(1, 2))
                                            : 3'($urandom_range(REQ_SET_VOLUME, REQ_QUERY));
      r.volume = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, VOL_TOP));
      case ($urandom_range(0, 5))
         0:       r.step = 9'($urandom);
         1, 2:    r.step = 9'($urandom_range(0, 20) - 10);
         default: r.step = 9'($urandom_range(0, 2 * VOL_TOP) - VOL_TOP);
      endcase
      r.channel = ($urandom_range(0, 6) == 0) ? 3'($urandom) : 3'($urandom_range(1, NCH));
      r.offset = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(0, 2 * lim) - lim);
      r.mute_on = 1'($urandom);
      return r;
   endfunction

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_cnt++;
      end
   endtask

   // wait for the block to go quiet, then let any trailing scan finish
   task automatic drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_forecast_q.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic program_csrs(csr_set_type c);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ACTIVE_MASK;
      csr_wdata    <= c.mask;
      @(posedge clock);
      csr_index <= CSR_OFFSET_LIMIT;
      csr_wdata <= c.limit;
      @(posedge clock);
      csr_index <= CSR_LINEAR;
      csr_wdata <= c.linear;
      @(posedge clock);
      csr_index <= CSR_BOOT_VOLUME;
      csr_wdata <= c.boot_vol;
      @(posedge clock);
      csr_index <= CSR_BOOT_MUTE;
      csr_wdata <= c.boot_mute;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_mask      = c.mask[5:0];
      cfg_limit     = c.limit;
      cfg_linear    = c.linear[0];
      cfg_boot_vol  = c.boot_vol;
      cfg_boot_mute = c.boot_mute[0];
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) forecast_request(cur_req);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(1, 10) - 1;
               req_valid <= 1'b0;
            end else begin
               cur_req = req_backlog.pop_front();
               req_valid   <= 1'b1;
               req_type    <= cur_req.kind;
               req_volume  <= cur_req.volume;
               req_step    <= cur_req.step;
               req_channel <= cur_req.channel;
               req_offset  <= cur_req.offset;
               req_mute_on <= cur_req.mute_on;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_forecast_q.size() == 0) begin
               $error("result with no request outstanding");
               mismatch_cnt++;
            end else begin
               want = rsp_forecast_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("write_valid", want.write_valid, rsp_write_valid);
               check_field("out_channel", want.channel, rsp_out_channel);
               check_field("attenuation", want.atten, rsp_attenuation);
               check_field("channel_offset", want.offset, rsp_channel_offset);
               check_field("volume_level", want.master, rsp_volume_level);
               check_field("muted", want.muted, rsp_muted);
               check_field("last", want.last, rsp_last);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      csr_set_type phases [NUM_PHASES];
      phases[0] = '{7'h7F, 7'd127, 7'd1, 7'd127, 7'd1};
      phases[1] = '{7'h00, 7'd0,   7'd0, 7'd0,   7'd0};
      phases[2] = '{7'h01, 7'd78,  7'd1, 7'd100, 7'd1};
      phases[3] = '{7'h60, 7'd40,  7'd0, 7'd50,  7'd0};
      phases[4] = '{7'($urandom_range(1, 63)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 1))};
      phases[5] = '{7'h3F, 7'd78,  7'd0, 7'd100, 7'd0};

      level = (cfg_boot_vol > VOL_TOP) ? 7'(VOL_TOP) : cfg_boot_vol;
      mute_state = cfg_boot_mute;
      for (int i = 0; i < NCH; i++) begin
         ofs_mem[i] = '0;
         att_mem[i] = 7'(ATTEN_TOP);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // channels 3 and 6 inactive
      program_csrs('{7'h1B, 7'd78, 7'd0, 7'd50, 7'd0});
      req_backlog.push_back(mk(REQ_SET_VOLUME, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_SET_VOLUME, 100, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_SET_VOLUME, 101, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_SET_VOLUME, 255, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, 100, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, -100, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, 101, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, -101, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_STEP_VOLUME, 0, -256, 0, 0, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 1, 78, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 2, -78, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 4, 79, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 3, 10, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 3, 100, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 0, 5, 0));
      req_backlog.push_back(mk(REQ_SET_OFFSET, 0, 0, 7, -5, 0));
      req_backlog.push_back(mk(REQ_SET_VOLUME, 60, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_QUERY, 0, 0, 1, 0, 0));
      req_backlog.push_back(mk(REQ_QUERY, 0, 0, 3, 0, 0));
      req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_QUERY, 0, 0, 7, 0, 0));
      req_backlog.push_back(mk(REQ_SET_MUTE, 0, 0, 0, 0, 1));
      req_backlog.push_back(mk(REQ_SET_MUTE, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_RESET_OFFSET, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(3'(REQ_QUERY + 2), 255, -1, 7, -1, 1));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         steady = (p == NUM_PHASES - 1);
         program_csrs(phases[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2) drain();
            req_backlog.push_back(random_request());
         end
         drain();
      end

      if (mismatch_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
